/* hw/rtl/i2cbe_pkg.sv */
package i2cbe_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [4:0] PH_IDLE = 5'd31;
	localparam logic [2:0] BIT_MSB = 3'd7;

	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_START = 3'd1,
		CMD_STOP  = 3'd2,
		CMD_SEND  = 3'd3,
		CMD_WAIT  = 3'd4,
		CMD_READ  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ACK_OK      = 2'd0,
		ACK_TIMEOUT = 2'd1,
		ACK_NOT_LOW = 2'd2
	} ack_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  write_byte;
		logic        send_ack;
		logic [14:0] ack_timeout;
		logic        sda_level;
	} item_t;

	typedef struct packed {
		logic       scl_drive;
		logic       sda_drive;
		logic       busy_res;
		logic       cmd_done;
		logic [7:0] read_data;
		logic [1:0] ack_status;
	} result_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [7:0]  write_byte;
		logic        send_ack;
		logic [14:0] ack_timeout;
		logic        sda_level;
	} tick_t;

endpackage

/* hw/rtl/i2cbe_fifo.sv */
module i2cbe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_COUNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/i2cbe_front.sv */
module i2cbe_front #(
	parameter int DEPTH = i2cbe_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  i2cbe_pkg::item_t    item,
	input  logic                tick_pop,
	output logic                tick_empty,
	output i2cbe_pkg::tick_t    tick
);
	import i2cbe_pkg::*;

	tick_t                cls;
	logic [$bits(tick_t)-1:0] tick_bits;

	always_comb begin
		cls.cmd         = (item.req_type inside {[CMD_START:CMD_READ]}) ?
			cmd_t'(item.req_type) : CMD_NONE;
		cls.write_byte  = item.write_byte;
		cls.send_ack    = item.send_ack;
		cls.ack_timeout = item.ack_timeout;
		cls.sda_level   = item.sda_level;
	end

	i2cbe_fifo #(
		.WIDTH($bits(tick_t)),
		.DEPTH(DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.wdata (cls),
		.pop   (tick_pop),
		.empty (tick_empty),
		.rdata (tick_bits)
	);

	assign tick = tick_t'(tick_bits);

endmodule

/* hw/rtl/i2cbe_back.sv */
module i2cbe_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_empty,
	output logic                tick_pop,
	input  i2cbe_pkg::tick_t    tick,
	input  logic                res_full,
	output logic                res_push,
	output i2cbe_pkg::result_t  res
);
	import i2cbe_pkg::*;

	cmd_t        act_q, act_n;
	logic [4:0]  ph_q, ph_n;
	logic [2:0]  bi_q, bi_n;
	logic [7:0]  sr_q, sr_n;
	logic [14:0] pc_q, pc_n;
	logic        af_q, af_n;
	logic        scl_q, scl_n;
	logic        sda_q, sda_n;
	ack_t        st_q, st_n;
	logic [7:0]  rx_q, rx_n;
	logic        fire, adv, done;

	assign fire     = !tick_empty && !res_full;
	assign tick_pop = fire;
	assign res_push = fire;

	always_comb begin
		act_n = act_q;
		ph_n  = ph_q;
		bi_n  = bi_q;
		sr_n  = sr_q;
		pc_n  = pc_q;
		af_n  = af_q;
		scl_n = scl_q;
		sda_n = sda_q;
		st_n  = st_q;
		rx_n  = rx_q;
		adv   = 1'b1;
		done  = 1'b0;

		if (act_q == CMD_NONE && tick.cmd != CMD_NONE) begin
			act_n = tick.cmd;
			ph_n  = '0;
			bi_n  = BIT_MSB;
			sr_n  = (tick.cmd == CMD_SEND) ? tick.write_byte : '0;
			af_n  = tick.send_ack;
			pc_n  = tick.ack_timeout;
		end

		case (act_n)
			CMD_START: begin
				case (ph_n)
					5'd0: scl_n = 1'b1;
					5'd1: sda_n = 1'b1;
					5'd3: sda_n = 1'b0;
					5'd5: begin
						scl_n = 1'b0;
						done  = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_STOP: begin
				case (ph_n)
					5'd0: scl_n = 1'b1;
					5'd1: sda_n = 1'b0;
					5'd3: begin
						sda_n = 1'b1;
						done  = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_SEND: begin
				case (ph_n)
					5'd0: scl_n = 1'b0;
					5'd1: sda_n = sr_n[bi_n];
					5'd3: scl_n = 1'b1;
					5'd4: begin
						adv = 1'b0;
						if (bi_n == '0) begin
							ph_n = 5'd5;
						end else begin
							bi_n = bi_n - 1'b1;
							ph_n = '0;
						end
					end
					5'd5: scl_n = 1'b0;
					5'd6: begin
						sda_n = 1'b1;
						done  = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_WAIT: begin
				case (ph_n)
					5'd0: begin
						adv = 1'b0;
						if (pc_n == '0) begin
							st_n = ACK_TIMEOUT;
							done = 1'b1;
						end else begin
							pc_n = pc_n - 1'b1;
							if (!tick.sda_level) begin
								ph_n = 5'd1;
							end
						end
					end
					5'd1: scl_n = 1'b1;
					5'd2: begin
						if (tick.sda_level) begin
							st_n = ACK_NOT_LOW;
							done = 1'b1;
						end
					end
					5'd3: scl_n = 1'b0;
					5'd4: begin
						st_n = ACK_OK;
						done = 1'b1;
					end
					default: ;
				endcase
			end
			CMD_READ: begin
				case (ph_n)
					5'd0: scl_n = 1'b0;
					5'd2: begin
						scl_n = 1'b1;
						sr_n  = {sr_n[6:0], tick.sda_level};
					end
					5'd3: begin
						adv = 1'b0;
						if (bi_n == '0) begin
							ph_n = 5'd4;
						end else begin
							bi_n = bi_n - 1'b1;
							ph_n = '0;
						end
					end
					5'd4: scl_n = 1'b0;
					5'd6: sda_n = !af_n;
					5'd7: scl_n = 1'b1;
					5'd9: begin
						scl_n = 1'b0;
						if (!af_n) begin
							rx_n = sr_n;
							done = 1'b1;
						end
					end
					5'd10: sda_n = 1'b1;
					5'd11: begin
						rx_n = sr_n;
						done = 1'b1;
					end
					default: ;
				endcase
			end
			default: adv = 1'b0;
		endcase

		if (done) begin
			act_n = CMD_NONE;
			ph_n  = PH_IDLE;
			bi_n  = BIT_MSB;
		end else if (adv) begin
			ph_n = ph_n + 1'b1;
		end

		res.scl_drive  = scl_n;
		res.sda_drive  = sda_n;
		res.busy_res   = (act_n != CMD_NONE);
		res.cmd_done   = done;
		res.read_data  = rx_n;
		res.ack_status = st_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= CMD_NONE;
			ph_q  <= PH_IDLE;
			bi_q  <= BIT_MSB;
			sr_q  <= '0;
			pc_q  <= '0;
			af_q  <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			st_q  <= ACK_OK;
			rx_q  <= '0;
		end else if (fire) begin
			act_q <= act_n;
			ph_q  <= ph_n;
			bi_q  <= bi_n;
			sr_q  <= sr_n;
			pc_q  <= pc_n;
			af_q  <= af_n;
			scl_q <= scl_n;
			sda_q <= sda_n;
			st_q  <= st_n;
			rx_q  <= rx_n;
		end
	end

endmodule

/* hw/rtl/i2c_master_bit_engine_unit.sv */
// channel   direction  handshake            payload
// item      in         push / full          i2cbe_pkg::item_t   (one bus tick)
// result    out        pop / empty          i2cbe_pkg::result_t (one per tick)
//
// Ticks enter one per cycle while full is low and pass the tick then result queue.
// The engine steps once per tick: one tick per cycle unless the result side stalls.
// Reset clears both queues and returns the engine to idle with SCL and SDA released.
// A stalled result side fills the result queue, then the tick queue, then raises full.
module i2c_master_bit_engine_unit #(
	parameter int QUEUE_DEPTH = i2cbe_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  i2cbe_pkg::item_t    item,
	input  logic                pop,
	output logic                empty,
	output i2cbe_pkg::result_t  result
);
	import i2cbe_pkg::*;

	tick_t                      tick;
	logic                       tick_empty, tick_pop;
	result_t                    res;
	logic                       res_push, res_full;
	logic [$bits(result_t)-1:0] result_bits;

	i2cbe_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.tick_pop  (tick_pop),
		.tick_empty(tick_empty),
		.tick      (tick)
	);

	i2cbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_empty(tick_empty),
		.tick_pop  (tick_pop),
		.tick      (tick),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res)
	);

	i2cbe_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_result_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.wdata (res),
		.pop   (pop),
		.empty (empty),
		.rdata (result_bits)
	);

	assign result = result_t'(result_bits);

endmodule

/* hw/rtl/i2cbe_checker.sv */
module i2cbe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                full,
	input logic                pop,
	input logic                empty,
	input i2cbe_pkg::result_t  result
);
	import i2cbe_pkg::*;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.cmd_done |-> !result.busy_res)
		else $error("finished transaction still reports busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.ack_status <= ACK_NOT_LOW)
		else $error("ack status outside defined codes");

	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input full while no result waits");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result transaction changed");

endmodule

bind i2c_master_bit_engine_unit i2cbe_checker u_checker (.*);
